>>> hw/rtl/ppmd_pkg.sv
// Package for the PPM stream decoder: phases, status codes, byte classes, types.
// No dependencies.
`timescale 1ns / 1ps
package ppmd_pkg;

  localparam int unsigned MaxDimDefault = 4096;
  localparam int unsigned AccMax        = 131071;

  typedef enum logic [3:0] {
    PH_MAGIC_P = 4'd0,
    PH_MAGIC_D = 4'd1,
    PH_WIDTH   = 4'd2,
    PH_HEIGHT  = 4'd3,
    PH_MAXVAL  = 4'd4,
    PH_DATA    = 4'd5,
    PH_DONE    = 4'd6,
    PH_ERROR   = 4'd7
  } phase_e;

  typedef enum logic [2:0] {
    ST_PIXEL     = 3'd0,
    ST_BAD_MAGIC = 3'd1,
    ST_BAD_HDR   = 3'd2,
    ST_TOO_BIG   = 3'd3,
    ST_TRUNC     = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    C_IDLE,
    C_DIV,
    C_OUT
  } ctrl_e;

  localparam logic [7:0] ChP    = 8'h50;
  localparam logic [7:0] Ch3    = 8'h33;
  localparam logic [7:0] Ch6    = 8'h36;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChLf   = 8'h0a;
  localparam logic [7:0] ChCr   = 8'h0d;

  // Commands from controller to datapath.
  typedef struct packed {
    logic parse;     // take the byte in the input register
    logic div_start; // load the divider
    logic div_step;  // one quotient bit
    logic finish;    // commit scaled sample
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic need_div;  // byte completed a valid sample
    logic emit;      // a result is to be delivered
    logic div_done;
  } stat_t;

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'd48 && b <= 8'd57;
  endfunction

endpackage

>>> hw/rtl/ppmd_if.sv
// Valid/ready channel interfaces for the PPM decoder.
// Depends on nothing.
`timescale 1ns / 1ps
interface ppmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       start_of_file;
  logic       end_of_file;
  modport source (output valid, byte_in, start_of_file, end_of_file, input ready);
  modport sink   (input valid, byte_in, start_of_file, end_of_file, output ready);
endinterface

interface ppmd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;
  modport source (output valid, status, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, status, red, green, blue, last_pixel, output ready);
endinterface

>>> hw/rtl/ppmd_ctrl.sv
// Sequencer of the PPM decoder: parse, divide, deliver.
// Depends on ppmd_pkg.
`timescale 1ns / 1ps
module ppmd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ppmd_pkg::stat_t   stat_i,
  output ppmd_pkg::cmd_t    cmd_o
);

  ppmd_pkg::ctrl_e state_q, state_d;
  logic            full_q, full_d;  // a byte waits in the datapath input register

  // Next state.
  always_comb begin
    state_d = state_q;
    full_d  = full_q;
    if (in_valid_i && in_ready_o) full_d = 1'b1;
    unique case (state_q)
      ppmd_pkg::C_IDLE: begin
        if (full_q) begin
          full_d = in_valid_i && in_ready_o;
          if (stat_i.need_div)  state_d = ppmd_pkg::C_DIV;
          else if (stat_i.emit) state_d = ppmd_pkg::C_OUT;
        end
      end
      ppmd_pkg::C_DIV: if (stat_i.div_done) state_d = stat_i.emit ? ppmd_pkg::C_OUT
                                                                  : ppmd_pkg::C_IDLE;
      ppmd_pkg::C_OUT: if (out_ready_i) state_d = ppmd_pkg::C_IDLE;
      default: state_d = ppmd_pkg::C_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o           = '0;
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    unique case (state_q)
      ppmd_pkg::C_IDLE: begin
        in_ready_o = !full_q || !(stat_i.need_div || stat_i.emit);
        cmd_o.parse     = full_q;
        cmd_o.div_start = full_q && stat_i.need_div;
      end
      ppmd_pkg::C_DIV: begin
        cmd_o.div_step = !stat_i.div_done;
        cmd_o.finish   = stat_i.div_done;
      end
      ppmd_pkg::C_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppmd_pkg::C_IDLE;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      full_q  <= full_d;
    end
  end

endmodule

>>> hw/rtl/ppmd_dp.sv
// Datapath of the PPM decoder: header parser, counters, restoring divider, result register.
// Depends on ppmd_pkg.
`timescale 1ns / 1ps
module ppmd_dp #(
  parameter int unsigned MAX_DIM = ppmd_pkg::MaxDimDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_load_i,
  input  logic [7:0]       byte_i,
  input  logic             sof_i,
  input  logic             eof_i,
  input  ppmd_pkg::cmd_t   cmd_i,
  output ppmd_pkg::stat_t  stat_o,
  output logic [2:0]       status_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic             last_o
);

  localparam logic [16:0] AccMax = 17'(ppmd_pkg::AccMax);
  localparam logic [16:0] DimMax = 17'(MAX_DIM);

  // Input byte register.
  logic [7:0] b_q;
  logic       sof_q, eof_q;
  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      b_q   <= byte_i;
      sof_q <= sof_i;
      eof_q <= eof_i;
    end
  end

  ppmd_pkg::phase_e ph_q, ph_d;
  logic        asc_q, asc_d, com_q, com_d, hd_q, hd_d;
  logic [16:0] acc_q, acc_d;
  logic [12:0] w_q, w_d, h_q, h_d, col_q, col_d, row_q, row_d;
  logic [15:0] mx_q, mx_d;
  logic [1:0]  ci_q, ci_d;
  logic [7:0]  hb_q, hb_d, rh_q, rh_d, gh_q, gh_d;
  logic        emit_q, emit_d;
  logic [2:0]  st_q, st_d;
  logic [7:0]  ro_q, ro_d, go_q, go_d, bo_q, bo_d;
  logic        lo_q, lo_d;
  logic        pend_eof_q, pend_eof_d; // end of file after the pending sample

  // Divider: 255*v / maxval over 24 dividend bits.
  logic [23:0] dq_q, dq_d;
  logic [16:0] rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;

  logic        have_samp;

  // Parse one byte; sample values above maxval fail here.
  always_comb begin
    logic [20:0] mul;
    logic [16:0] v;
    logic        fin;
    logic [16:0] rs;
    ph_d = ph_q; asc_d = asc_q; com_d = com_q; hd_d = hd_q; acc_d = acc_q;
    w_d = w_q; h_d = h_q; mx_d = mx_q; col_d = col_q; row_d = row_q; ci_d = ci_q;
    hb_d = hb_q; rh_d = rh_q; gh_d = gh_q;
    emit_d = emit_q; st_d = st_q; ro_d = ro_q; go_d = go_q; bo_d = bo_q; lo_d = lo_q;
    pend_eof_d = pend_eof_q;
    dq_d = dq_q; rem_d = rem_q; cnt_d = cnt_q; busy_d = busy_q;
    have_samp = 1'b0;
    mul = '0; v = '0; fin = 1'b0; rs = '0;

    if (cmd_i.parse) begin
      emit_d = 1'b0;
      if (sof_q) begin
        ph_d = ppmd_pkg::PH_MAGIC_P; asc_d = 1'b0; com_d = 1'b0; hd_d = 1'b0; acc_d = '0;
        w_d = '0; h_d = '0; mx_d = '0; col_d = '0; row_d = '0; ci_d = '0;
        hb_d = '0; rh_d = '0; gh_d = '0;
      end
      mul = {acc_d, 3'b0} + {2'b0, acc_d, 1'b0} + 21'(b_q - 8'd48);
      unique case (ph_d)
        ppmd_pkg::PH_MAGIC_P:
          if (b_q == ppmd_pkg::ChP) ph_d = ppmd_pkg::PH_MAGIC_D;
          else begin ph_d = ppmd_pkg::PH_ERROR; emit_d = 1'b1;
            st_d = ppmd_pkg::ST_BAD_MAGIC; end
        ppmd_pkg::PH_MAGIC_D:
          if (b_q == ppmd_pkg::Ch3) begin asc_d = 1'b1; ph_d = ppmd_pkg::PH_WIDTH; end
          else if (b_q == ppmd_pkg::Ch6) begin asc_d = 1'b0; ph_d = ppmd_pkg::PH_WIDTH; end
          else begin ph_d = ppmd_pkg::PH_ERROR; emit_d = 1'b1;
            st_d = ppmd_pkg::ST_BAD_MAGIC; end
        ppmd_pkg::PH_WIDTH, ppmd_pkg::PH_HEIGHT, ppmd_pkg::PH_MAXVAL, ppmd_pkg::PH_DATA: begin
          if (ph_d == ppmd_pkg::PH_DATA && !asc_d) begin
            // Binary samples.
            if (mx_d > 16'd255) begin
              if (!hd_d) begin hb_d = b_q; hd_d = 1'b1; end
              else begin hd_d = 1'b0; v = {1'b0, hb_d, b_q}; fin = 1'b1; end
            end else begin v = {9'b0, b_q}; fin = 1'b1; end
          end else if (com_d) begin
            if (b_q == ppmd_pkg::ChLf || b_q == ppmd_pkg::ChCr) com_d = 1'b0;
          end else if (ppmd_pkg::is_digit(b_q)) begin
            acc_d = (mul > {4'b0, AccMax}) ? AccMax : mul[16:0];
            hd_d  = 1'b1;
          end else if (ppmd_pkg::is_space(b_q) || b_q == ppmd_pkg::ChHash) begin
            if (hd_d) begin
              rs = acc_d; acc_d = '0; hd_d = 1'b0;
              if (ph_d == ppmd_pkg::PH_DATA) begin v = rs; fin = 1'b1; end
              else if (ph_d == ppmd_pkg::PH_MAXVAL && b_q == ppmd_pkg::ChHash) begin
                ph_d = ppmd_pkg::PH_ERROR; emit_d = 1'b1; st_d = ppmd_pkg::ST_BAD_HDR;
              end else if (ph_d == ppmd_pkg::PH_WIDTH) begin
                if (rs < 17'd1 || rs > DimMax) begin ph_d = ppmd_pkg::PH_ERROR;
                  emit_d = 1'b1; st_d = ppmd_pkg::ST_BAD_HDR; end
                else begin w_d = rs[12:0]; ph_d = ppmd_pkg::PH_HEIGHT; end
              end else if (ph_d == ppmd_pkg::PH_HEIGHT) begin
                if (rs < 17'd1 || rs > DimMax) begin ph_d = ppmd_pkg::PH_ERROR;
                  emit_d = 1'b1; st_d = ppmd_pkg::ST_BAD_HDR; end
                else begin h_d = rs[12:0]; ph_d = ppmd_pkg::PH_MAXVAL; end
              end else begin
                if (rs < 17'd1 || rs > 17'd65535) begin ph_d = ppmd_pkg::PH_ERROR;
                  emit_d = 1'b1; st_d = ppmd_pkg::ST_BAD_HDR; end
                else begin mx_d = rs[15:0]; ph_d = ppmd_pkg::PH_DATA;
                  col_d = '0; row_d = '0; ci_d = '0; end
              end
            end
            if (b_q == ppmd_pkg::ChHash && ph_d != ppmd_pkg::PH_ERROR && !fin) com_d = 1'b1;
            if (b_q == ppmd_pkg::ChHash && fin) com_d = 1'b1;
          end else begin
            ph_d = ppmd_pkg::PH_ERROR; emit_d = 1'b1; st_d = ppmd_pkg::ST_BAD_HDR;
          end
        end
        default: ;
      endcase
      // Sample finished by end of file.
      if (eof_q && !fin && ph_d == ppmd_pkg::PH_DATA && asc_d && hd_d && !com_d &&
          !emit_d) begin
        v = acc_d; acc_d = '0; hd_d = 1'b0; fin = 1'b1;
      end
      pend_eof_d = eof_q;
      if (fin) begin
        if (v > {1'b0, mx_d}) begin
          ph_d = ppmd_pkg::PH_ERROR; emit_d = 1'b1; st_d = ppmd_pkg::ST_TOO_BIG;
        end else begin
          have_samp = 1'b1;
          dq_d = {v[15:0], 8'b0} - {8'b0, v[15:0]};
          rem_d = '0; cnt_d = '0; busy_d = 1'b1;
        end
      end
      if (!have_samp && eof_q && ph_d != ppmd_pkg::PH_DONE && ph_d != ppmd_pkg::PH_ERROR) begin
        emit_d = 1'b1;
        st_d = (ph_d <= ppmd_pkg::PH_MAGIC_D) ? ppmd_pkg::ST_BAD_MAGIC :
               (ph_d < ppmd_pkg::PH_DATA) ? ppmd_pkg::ST_BAD_HDR : ppmd_pkg::ST_TRUNC;
        ph_d = ppmd_pkg::PH_ERROR;
      end
      if (emit_d) begin ro_d = '0; go_d = '0; bo_d = '0; lo_d = 1'b0; end
    end

    // One restoring quotient bit per step.
    if (cmd_i.div_step) begin
      rs = {rem_q[15:0], dq_q[23]};
      if (rs >= {1'b0, mx_q}) begin rs = rs - {1'b0, mx_q}; dq_d = {dq_q[22:0], 1'b1}; end
      else dq_d = {dq_q[22:0], 1'b0};
      rem_d = rs; cnt_d = cnt_q + 5'd1;
    end

    // Commit scaled sample; maybe a pixel.
    if (cmd_i.finish) begin
      busy_d = 1'b0;
      if (ci_q == 2'd0) begin rh_d = dq_q[7:0]; ci_d = 2'd1; end
      else if (ci_q == 2'd1) begin gh_d = dq_q[7:0]; ci_d = 2'd2; end
      else begin
        ci_d = 2'd0; emit_d = 1'b1; st_d = ppmd_pkg::ST_PIXEL;
        ro_d = rh_q; go_d = gh_q; bo_d = dq_q[7:0];
        lo_d = (col_q + 13'd1 >= w_q) && (row_q + 13'd1 >= h_q);
        if (lo_d) ph_d = ppmd_pkg::PH_DONE;
        else begin
          col_d = col_q + 13'd1;
          if (col_d >= w_q) begin col_d = '0; row_d = row_q + 13'd1; end
        end
      end
      if (pend_eof_q && ph_d != ppmd_pkg::PH_DONE) begin
        ph_d = ppmd_pkg::PH_ERROR; emit_d = 1'b1; st_d = ppmd_pkg::ST_TRUNC;
        ro_d = '0; go_d = '0; bo_d = '0; lo_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= ppmd_pkg::PH_MAGIC_P; asc_q <= 1'b0; com_q <= 1'b0; hd_q <= 1'b0;
      acc_q <= '0; w_q <= '0; h_q <= '0; mx_q <= '0; col_q <= '0; row_q <= '0;
      ci_q <= '0; hb_q <= '0; rh_q <= '0; gh_q <= '0; emit_q <= 1'b0;
      busy_q <= 1'b0; cnt_q <= '0; pend_eof_q <= 1'b0;
    end else begin
      ph_q <= ph_d; asc_q <= asc_d; com_q <= com_d; hd_q <= hd_d;
      acc_q <= acc_d; w_q <= w_d; h_q <= h_d; mx_q <= mx_d; col_q <= col_d; row_q <= row_d;
      ci_q <= ci_d; hb_q <= hb_d; rh_q <= rh_d; gh_q <= gh_d; emit_q <= emit_d;
      busy_q <= busy_d; cnt_q <= cnt_d; pend_eof_q <= pend_eof_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d; ro_q <= ro_d; go_q <= go_d; bo_q <= bo_d; lo_q <= lo_d;
    dq_q <= dq_d; rem_q <= rem_d;
  end

  // Status is combinational on the parse cycle so the controller branches at once.
  assign stat_o.need_div = cmd_i.parse && have_samp;
  assign stat_o.emit     = cmd_i.parse ? emit_d : emit_d;
  assign stat_o.div_done = busy_q && cnt_q == 5'd24;
  assign status_o = st_q;
  assign red_o    = ro_q;
  assign green_o  = go_q;
  assign blue_o   = bo_q;
  assign last_o   = lo_q;

endmodule

>>> hw/rtl/ppm_image_stream_decoder_top.sv
// Top level of the PPM P3/P6 stream decoder.
// Depends on ppmd_pkg, ppmd_if, ppmd_ctrl and ppmd_dp.
//
//   channel  direction  payload
//   in_if    sink       byte_in, start_of_file, end_of_file
//   out_if   source     status, red, green, blue, last_pixel
//
// A byte that completes no sample and raises no result is parsed in the cycle after it
// is taken, and the next byte is taken in that same cycle, so such bytes stream at one
// per cycle. A byte that completes a sample holds the input through the parse, 24 steps
// of the restoring divider for 255*v/maxval, the commit and the next accept.
// A result waits in the output register until taken; no byte is taken meanwhile.
// Reset is asynchronous and active low and clears all parse state.
`timescale 1ns / 1ps
module ppm_image_stream_decoder_top #(
  parameter int unsigned MAX_DIM = ppmd_pkg::MaxDimDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  ppmd_in_if.sink    in_if,
  ppmd_out_if.source out_if
);

  ppmd_pkg::cmd_t  cmd;
  ppmd_pkg::stat_t stat;
  logic            load;

  assign load = in_if.valid && in_if.ready;

  ppmd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ppmd_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk_i, .rst_ni,
    .in_load_i(load),
    .byte_i   (in_if.byte_in),
    .sof_i    (in_if.start_of_file),
    .eof_i    (in_if.end_of_file),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .status_o (out_if.status),
    .red_o    (out_if.red),
    .green_o  (out_if.green),
    .blue_o   (out_if.blue),
    .last_o   (out_if.last_pixel)
  );

endmodule

>>> hw/rtl/ppmd_checker.sv
// Port checker for the PPM decoder, bound to the top level.
// Depends on the top level's ports and on ppmd_pkg for the status codes.
`timescale 1ns / 1ps
module ppmd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [7:0] red,
  input logic       last_pixel
);

  // A result never coexists with taking a new item.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // Status codes stay in range.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> status <= ppmd_pkg::ST_TRUNC) else $error("bad status");

  // Error results carry zero payload; red and last_pixel are checked.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != ppmd_pkg::ST_PIXEL |-> red == 8'd0 && !last_pixel)
    else $error("error result with payload");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped");

  // An offered item stays offered until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_ready |=> in_valid)
    else $error("input item withdrawn");

endmodule

bind ppm_image_stream_decoder_top ppmd_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .status    (out_if.status),
  .red       (out_if.red),
  .last_pixel(out_if.last_pixel)
);
